### src/fmmd_pkg.sv
// shared types, constants and the restoring divide step for the mantissa multiply/divide unit
package fmmd_pkg;

   localparam int MANT_WIDTH_DEF = 53;
   localparam int MANT_BITS      = 53;
   localparam int REM_BITS       = 64;
   localparam int EXP_BITS       = 13;
   localparam int HALF_LO        = 27;
   localparam int HALF_HI        = MANT_BITS - HALF_LO;
   localparam int PP_BITS        = 2 * HALF_LO;
   localparam int PROD_BITS      = 2 * MANT_BITS;
   localparam int ACC_BITS       = MANT_BITS + 1;

   localparam logic signed [EXP_BITS-1:0] EXP_BIAS = 13'sd1023;

   localparam logic CMD_MUL = 1'b0;
   localparam logic CMD_DIV = 1'b1;

   localparam logic [1:0] ST_NORMAL  = 2'd0;
   localparam logic [1:0] ST_ZERO    = 2'd1;
   localparam logic [1:0] ST_DIVZERO = 2'd2;

   typedef struct packed {
      logic                       cmd;
      logic [1:0]                 stat;
      logic                       sign;
      logic signed [EXP_BITS-1:0] exp;
      logic [REM_BITS-1:0]        rem;
      logic [MANT_BITS-1:0]       q;
      logic [MANT_BITS-1:0]       dvs;
   } fmmd_item_type;

   // one restoring step: compare, subtract, shift the 64-bit remainder
   function automatic fmmd_item_type div_step(input fmmd_item_type it);
      fmmd_item_type       res;
      logic                ge;
      logic [REM_BITS-1:0] dvs_ext;
      logic [REM_BITS-1:0] diff;
      dvs_ext = {{(REM_BITS-MANT_BITS){1'b0}}, it.dvs};
      ge      = it.rem >= dvs_ext;
      diff    = ge ? it.rem - dvs_ext : it.rem;
      res     = it;
      res.q   = {it.q[MANT_BITS-2:0], ge};
      res.rem = {diff[REM_BITS-2:0], 1'b0};
      return res;
   endfunction

endpackage

### src/fmmd_stage.sv
// one pipeline stage of the divider: a single restoring step per divide request, multiply requests pass unchanged
module fmmd_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  fmmd_pkg::fmmd_item_type in_item,
   output logic                   in_ready,
   output logic                   out_valid,
   output fmmd_pkg::fmmd_item_type out_item,
   input  logic                   out_ready
);
   import fmmd_pkg::*;

   logic          valid_ff, valid_in;
   fmmd_item_type item_ff, item_in;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      item_in = item_ff;
      if (in_ready && in_valid) begin
         item_in = (in_item.cmd == CMD_DIV) ? div_step(in_item) : in_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

### src/fmmd_front.sv
// front stages: operand decode, partial products, product sum and first two divide steps
module fmmd_front #(
   parameter int MANT_WIDTH = fmmd_pkg::MANT_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic                   command,
   input  logic                   sign_a,
   input  logic [10:0]            exp_a,
   input  logic [52:0]            mant_a,
   input  logic                   sign_b,
   input  logic [10:0]            exp_b,
   input  logic [52:0]            mant_b,
   output logic                   out_valid,
   output fmmd_pkg::fmmd_item_type out_item,
   input  logic                   out_ready
);
   import fmmd_pkg::*;

   localparam logic [MANT_BITS-1:0] MANT_MASK = {MANT_BITS{1'b1}} >> (MANT_BITS - MANT_WIDTH);

   typedef struct packed {
      fmmd_item_type      it;
      logic [PP_BITS-1:0] pp0;
      logic [PP_BITS-1:0] pp1;
      logic [PP_BITS-1:0] pp2;
      logic [PP_BITS-1:0] pp3;
   } pp_type;

   logic          v0_ff, v0_in, v1_ff, v1_in, v2_ff, v2_in;
   logic          r0, r1, r2;
   fmmd_item_type s0_ff, s0_in;
   pp_type        s1_ff, s1_in;
   fmmd_item_type s2_ff, s2_in;

   logic [MANT_BITS-1:0]       ma, mb;
   logic signed [EXP_BITS-1:0] ea, eb;
   logic [1:0]                 stat;
   logic [HALF_LO-1:0]         al, bl;
   logic [HALF_HI-1:0]         ah, bh;
   logic [PROD_BITS-1:0]       prod;
   logic [ACC_BITS-1:0]        acc;

   assign r2       = !v2_ff || out_ready;
   assign r1       = !v1_ff || r2;
   assign r0       = !v0_ff || r1;
   assign in_ready = r0;

   assign v0_in = r0 ? in_valid : v0_ff;
   assign v1_in = r1 ? v0_ff : v1_ff;
   assign v2_in = r2 ? v1_ff : v2_ff;

   // decode
   assign ma = mant_a & MANT_MASK;
   assign mb = mant_b & MANT_MASK;
   assign ea = $signed({2'b00, exp_a});
   assign eb = $signed({2'b00, exp_b});

   always_comb begin
      if (command == CMD_DIV) begin
         stat = (mb == '0) ? ST_DIVZERO : ((ma == '0) ? ST_ZERO : ST_NORMAL);
      end else begin
         stat = (ma == '0 || mb == '0) ? ST_ZERO : ST_NORMAL;
      end
   end

   always_comb begin
      s0_in = s0_ff;
      if (r0 && in_valid) begin
         s0_in.cmd  = command;
         s0_in.stat = stat;
         s0_in.sign = sign_a ^ sign_b;
         s0_in.exp  = (command == CMD_DIV) ? ea - eb + EXP_BIAS : ea + eb - EXP_BIAS;
         s0_in.rem  = {{(REM_BITS-MANT_BITS){1'b0}}, ma};
         s0_in.q    = '0;
         s0_in.dvs  = mb;
      end
   end

   // partial products, first divide step
   assign al = s0_ff.rem[HALF_LO-1:0];
   assign ah = s0_ff.rem[MANT_BITS-1:HALF_LO];
   assign bl = s0_ff.dvs[HALF_LO-1:0];
   assign bh = s0_ff.dvs[MANT_BITS-1:HALF_LO];

   always_comb begin
      s1_in = s1_ff;
      if (r1 && v0_ff) begin
         s1_in.it  = (s0_ff.cmd == CMD_DIV) ? div_step(s0_ff) : s0_ff;
         s1_in.pp0 = PP_BITS'(al * bl);
         s1_in.pp1 = PP_BITS'(al * bh);
         s1_in.pp2 = PP_BITS'(ah * bl);
         s1_in.pp3 = PP_BITS'(ah * bh);
      end
   end

   // product sum, second divide step
   assign prod = PROD_BITS'(s1_ff.pp0)
               + ((PROD_BITS'(s1_ff.pp1) + PROD_BITS'(s1_ff.pp2)) << HALF_LO)
               + (PROD_BITS'(s1_ff.pp3) << (2 * HALF_LO));
   assign acc  = prod[MANT_WIDTH-1 +: ACC_BITS];

   always_comb begin
      s2_in = s2_ff;
      if (r2 && v1_ff) begin
         if (s1_ff.it.cmd == CMD_DIV) begin
            s2_in = div_step(s1_ff.it);
         end else begin
            s2_in     = s1_ff.it;
            s2_in.rem = {{(REM_BITS-ACC_BITS){1'b0}}, acc};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v0_ff <= v0_in;
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
      s0_ff <= s0_in;
      s1_ff <= s1_in;
      s2_ff <= s2_in;
   end

   assign out_valid = v2_ff;
   assign out_item  = s2_ff;

endmodule

### src/fp_mantissa_multiply_divide.sv
// top level: mantissa mul/div pipeline with one restoring step per divide stage
// requests pass the front stages, the divide stages and the response register
// throughput one request per cycle unless stalled; divide stages set the depth
// every stage holds its request while the next one is full, bubbles are filled
// synchronous reset clears only the valid bits of all stages
module fp_mantissa_multiply_divide #(
   parameter int MANT_WIDTH = fmmd_pkg::MANT_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic        req_sign_a,
   input  logic [10:0] req_exp_a,
   input  logic [52:0] req_mant_a,
   input  logic        req_sign_b,
   input  logic [10:0] req_exp_b,
   input  logic [52:0] req_mant_b,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_res_sign,
   output logic signed [12:0] rsp_res_exp,
   output logic [52:0] rsp_res_mant,
   output logic [1:0]  rsp_status
);
   import fmmd_pkg::*;

   localparam int NSTAGE = MANT_WIDTH - 2;

   logic          ch_valid [NSTAGE+1];
   logic          ch_ready [NSTAGE+1];
   fmmd_item_type ch_item  [NSTAGE+1];
   logic          front_ready;

   fmmd_front #(.MANT_WIDTH(MANT_WIDTH)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (front_ready),
      .command   (req_command),
      .sign_a    (req_sign_a),
      .exp_a     (req_exp_a),
      .mant_a    (req_mant_a),
      .sign_b    (req_sign_b),
      .exp_b     (req_exp_b),
      .mant_b    (req_mant_b),
      .out_valid (ch_valid[0]),
      .out_item  (ch_item[0]),
      .out_ready (ch_ready[0])
   );

   assign req_stall = !front_ready;

   for (genvar k = 0; k < NSTAGE; k++) begin : g_div
      fmmd_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (ch_valid[k]),
         .in_item   (ch_item[k]),
         .in_ready  (ch_ready[k]),
         .out_valid (ch_valid[k+1]),
         .out_item  (ch_item[k+1]),
         .out_ready (ch_ready[k+1])
      );
   end

   // normalize and register the response
   fmmd_item_type              last;
   logic                       out_ready;
   logic [ACC_BITS-1:0]        m54;
   logic [MANT_BITS-1:0]       mant;
   logic signed [EXP_BITS-1:0] exp_n;
   logic                       valid_ff, valid_in;
   logic                       sign_ff, sign_in;
   logic signed [EXP_BITS-1:0] exp_ff, exp_in;
   logic [MANT_BITS-1:0]       mant_ff, mant_in;
   logic [1:0]                 stat_ff, stat_in;

   assign last      = ch_item[NSTAGE];
   assign out_ready = !valid_ff || !rsp_stall;
   assign ch_ready[NSTAGE] = out_ready;
   assign valid_in  = out_ready ? ch_valid[NSTAGE] : valid_ff;

   always_comb begin
      if (last.cmd == CMD_DIV) begin
         if (!last.q[MANT_WIDTH-1]) begin
            m54   = {last.q, 1'b0};
            exp_n = last.exp - 13'sd1;
         end else begin
            m54   = {1'b0, last.q};
            exp_n = last.exp;
         end
      end else begin
         if (last.rem[MANT_WIDTH]) begin
            m54   = last.rem[ACC_BITS:1];
            exp_n = last.exp + 13'sd1;
         end else begin
            m54   = last.rem[ACC_BITS-1:0];
            exp_n = last.exp;
         end
      end
      mant = m54[MANT_BITS-1:0];
   end

   always_comb begin
      sign_in = sign_ff;
      exp_in  = exp_ff;
      mant_in = mant_ff;
      stat_in = stat_ff;
      if (out_ready && ch_valid[NSTAGE]) begin
         if (last.stat != ST_NORMAL || mant == '0) begin
            sign_in = 1'b0;
            exp_in  = '0;
            mant_in = '0;
            stat_in = (last.stat == ST_NORMAL) ? ST_ZERO : last.stat;
         end else begin
            sign_in = last.sign;
            exp_in  = exp_n;
            mant_in = mant;
            stat_in = ST_NORMAL;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      sign_ff <= sign_in;
      exp_ff  <= exp_in;
      mant_ff <= mant_in;
      stat_ff <= stat_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_res_sign = sign_ff;
   assign rsp_res_exp  = exp_ff;
   assign rsp_res_mant = mant_ff;
   assign rsp_status   = stat_ff;

`ifndef SYNTH
   a_special_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_NORMAL |->
         rsp_res_mant == '0 && rsp_res_exp == '0 && !rsp_res_sign)
      else $error("special response carries payload");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == ST_NORMAL || rsp_status == ST_ZERO ||
                    rsp_status == ST_DIVZERO)
      else $error("bad status code");

   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with empty output");

   a_normal_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_NORMAL |-> rsp_res_mant != '0)
      else $error("normal response with zero mantissa");
`endif

endmodule
